@@ sv/atsc_pkg.sv @@
// Package for the antenna tuner search controller.
// Holds phase codes, status and wait codes, shared types and constants.
package atsc_pkg;

  localparam int unsigned RelayMaxDefault = 127;
  localparam int unsigned HystDiv = 20;
  localparam int unsigned Sw1KeepLimit = 200;
  localparam int unsigned Sw1KeepGain = 100;
  localparam int unsigned PwrWaitTries = 20;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_POWER = 3'd0,
    CFG_SWR_OK = 3'd1,
    CFG_SWR_GOOD = 3'd2,
    CFG_COARSE_STEP = 3'd3,
    CFG_RETRY_WAIT = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE, PH_FIRST, PH_PWRWAIT, PH_BYPASS, PH_CC_BASE, PH_CC_STEP, PH_CT_MEAS,
    PH_AFTER_COARSE, PH_SH_BASE, PH_SH_STEP, PH_AFTER_SHARP, PH_SW2_FIRST, PH_RETRY
  } phase_e;

  typedef enum logic [3:0] {
    ST_NONE = 4'd0, ST_NOPWR = 4'd1, ST_BYPASS = 4'd2, ST_RETRY = 4'd3,
    ST_COARSE_END = 4'd4, ST_CAP_DONE = 4'd5, ST_IND_DONE = 4'd6, ST_COARSE = 4'd7,
    ST_SW_TRY = 4'd8, ST_SW_BACK = 4'd9, ST_SW_KEEP = 4'd10, ST_FINE = 4'd11,
    ST_OK = 4'd12, ST_DONE = 4'd13, ST_ABORT = 4'd14, ST_SKIP = 4'd15
  } status_e;

  typedef enum logic [2:0] {
    W_NONE = 3'd0, W_10MS = 3'd1, W_50MS = 3'd2, W_200MS = 3'd3, W_500MS = 3'd4,
    W_RETRY = 3'd5
  } wait_e;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic start;
    logic [15:0] g;
  } item_t;

  typedef struct packed {
    logic [6:0] ind_bits;
    logic [6:0] cap_bits;
    logic sw_pos;
    logic measure;
    logic [2:0] wait_class;
    logic [3:0] status;
    logic finished;
    logic last;
  } res_t;

  function automatic logic [16:0] hyst(input logic [16:0] g);
    logic [16:0] q;
    q = 17'((34'(g) * 34'd52429) >> 20);
    if (17'(q * 17'd20) > g) q = q - 17'd1;
    return g + q;
  endfunction

endpackage

@@ sv/atsc_if.sv @@
// Valid/ready channel interfaces for the tuner controller.
// Uses no package.
interface atsc_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic [15:0] swr;
  logic [15:0] power;
  modport source(output valid, kind, swr, power, input ready);
  modport sink(input valid, kind, swr, power, output ready);
endinterface

interface atsc_out_if;
  logic valid;
  logic ready;
  logic [6:0] ind_bits;
  logic [6:0] cap_bits;
  logic sw_pos;
  logic measure;
  logic [2:0] wait_class;
  logic [3:0] status;
  logic finished;
  logic last;
  modport source(output valid, ind_bits, cap_bits, sw_pos, measure, wait_class, status,
                 finished, last, input ready);
  modport sink(input valid, ind_bits, cap_bits, sw_pos, measure, wait_class, status,
               finished, last, output ready);
endinterface

interface atsc_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ sv/atsc_front.sv @@
// Front part: accepts input items, classifies power loss, and queues them.
// Depends on atsc_pkg.
module atsc_front import atsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] min_power_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [15:0] swr_i,
  input  logic [15:0] power_i,
  output logic        q_valid_o,
  input  logic        q_ready_i,
  output item_t       q_item_o
);
  // Two-entry queue.
  item_t       mem_q [2];
  logic        wp_q, wp_d, rp_q, rp_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;
  item_t       it;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_item_o = mem_q[rp_q];

  always_comb begin
    it.start = !kind_i;
    it.g = (power_i < min_power_i) ? 16'd0 : swr_i;
    wp_d = push ? !wp_q : wp_q;
    rp_d = pop ? !rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= it;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1)) else $error("count slip");
endmodule

@@ sv/atsc_back.sv @@
// Back part: the search state machine, which turns each classified item into
// up to three results and plays them out through an output register. Depends on atsc_pkg.
module atsc_back import atsc_pkg::*; #(
  parameter int unsigned RelayMax = RelayMaxDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [9:0]  swr_ok_i,
  input  logic [9:0]  swr_good_i,
  input  logic [4:0]  coarse_step_i,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  item_t       q_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output res_t        out_res_o
);
  localparam int unsigned PW = $clog2(RelayMax + 1);
  localparam int unsigned CW = PW + 1;
  localparam logic [CW-1:0] RMAX = CW'(RelayMax);

  phase_e phase_q, phase_d;
  logic [PW-1:0] ind_now_q, ind_now_d, cap_now_q, cap_now_d, rel_ind_q, rel_ind_d;
  logic [PW-1:0] rel_cap_q, rel_cap_d, saved_cap_q, saved_cap_d, best_q, best_d;
  logic [PW-1:0] first_ind_q, first_ind_d, first_cap_q, first_cap_d;
  logic sw_q, sw_d, axis_cap_q, axis_cap_d, fine_q, fine_d, second_q, second_d;
  logic [5:0] ind_span_q, ind_span_d, cap_span_q, cap_span_d, scs_q, scs_d;
  logic [CW-1:0] outer_q, outer_d, inner_q, inner_d;
  logic [16:0] outer_min_q, outer_min_d, inner_min_q, inner_min_d;
  logic [15:0] first_swr_q, first_swr_d, cur_q, cur_d;
  logic [1:0] rem_q, rem_d;
  logic [4:0] pw_q, pw_d;

  // Result buffer: three slots and a count, drained one per cycle while the receiver is ready.
  res_t rb_q [3];
  res_t rb_d [3];
  logic [1:0] rn_q, rn_d, rp_q, rp_d;
  logic [1:0] n;
  logic busy;

  assign busy = (rn_q != 2'd0);
  assign q_ready_o = !busy || (rn_q - rp_q == 2'd1 && out_ready_i);
  assign out_valid_o = busy;
  assign out_res_o = rb_q[rp_q];

  always_comb begin
    logic [15:0] g;
    logic [4:0] st;
    logic [PW-1:0] pos;
    logic [5:0] span;
    logic [CW-1:0] hi, sum;
    logic fsh, sub, post, ctm, ctf, cc, ct, cts, sha, she, shl, shs, sas;
    logic sas_kind, fsh_cap;
    g = q_item_i.g;
    st = (coarse_step_i == 5'd0) ? 5'd1 : coarse_step_i;
    phase_d = phase_q; ind_now_d = ind_now_q; cap_now_d = cap_now_q; rel_ind_d = rel_ind_q;
    rel_cap_d = rel_cap_q; saved_cap_d = saved_cap_q; best_d = best_q;
    first_ind_d = first_ind_q; first_cap_d = first_cap_q; sw_d = sw_q;
    axis_cap_d = axis_cap_q; fine_d = fine_q; second_d = second_q;
    ind_span_d = ind_span_q; cap_span_d = cap_span_q; scs_d = scs_q;
    outer_d = outer_q; inner_d = inner_q; outer_min_d = outer_min_q;
    inner_min_d = inner_min_q; first_swr_d = first_swr_q; cur_d = cur_q;
    rem_d = rem_q; pw_d = pw_q;
    for (int i = 0; i < 3; i++) rb_d[i] = rb_q[i];
    rn_d = rn_q; rp_d = rp_q;
    n = 2'd0;
    pos = '0; span = '0; hi = '0; sum = '0;
    fsh = 0; sub = 0; post = 0; ctm = 0; ctf = 0; cc = 0; ct = 0; cts = 0;
    sha = 0; she = 0; shl = 0; shs = 0; sas = 0; sas_kind = 0; fsh_cap = 0;

    if (busy && out_ready_i) begin
      rp_d = rp_q + 2'd1;
      if (rp_q + 2'd1 == rn_q) begin
        rn_d = 2'd0;
        rp_d = 2'd0;
      end
    end

    if (q_valid_i && q_ready_o) begin
      rn_d = 2'd0; rp_d = 2'd0;
      // Results are emitted through a small macro-like sequence below.
      if (q_item_i.start) begin
        rem_d = 0; pw_d = 0; second_d = 0;
        phase_d = PH_FIRST;
        rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b1, W_NONE, ST_NONE, 1'b0, 1'b0};
        n = n + 2'd1;
      end else if (phase_q != PH_IDLE) begin
        cur_d = g;
        if ((phase_q == PH_CC_BASE || phase_q == PH_CC_STEP || phase_q == PH_CT_MEAS) &&
            g == 0 && rem_q == 0) begin
          rem_d = 1;
          rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b1, W_200MS, ST_NONE, 2'b00};
          n = n + 2'd1;
        end else begin
          unique case (phase_q)
            PH_FIRST: begin
              if (g == 0) begin
                rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b0, W_NONE, ST_NOPWR, 2'b00};
                n = n + 2'd1;
                pw_d = 0; phase_d = PH_PWRWAIT;
                rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b1, W_500MS, ST_NONE, 2'b00};
                n = n + 2'd1;
              end else if (g < 16'(swr_good_i)) begin
                phase_d = PH_IDLE;
                rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b0, W_NONE, ST_SKIP, 2'b10};
                n = n + 2'd1;
              end else begin
                ind_now_d = 0; cap_now_d = 0; sw_d = 0; rel_ind_d = 0; rel_cap_d = 0;
                phase_d = PH_BYPASS;
                rb_d[n] = {14'd0, 1'b0, 1'b1, W_50MS, ST_NONE, 2'b00};
                n = n + 2'd1;
              end
            end
            PH_PWRWAIT: begin
              pw_d = pw_q + 5'd1;
              if (g != 0) begin
                ind_now_d = 0; cap_now_d = 0; sw_d = 0; rel_ind_d = 0; rel_cap_d = 0;
                phase_d = PH_BYPASS;
                rb_d[n] = {14'd0, 1'b0, 1'b1, W_50MS, ST_NONE, 2'b00};
                n = n + 2'd1;
              end else if (pw_d < 5'(PwrWaitTries)) begin
                rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b1, W_500MS, ST_NONE, 2'b00};
                n = n + 2'd1;
              end else begin
                phase_d = PH_IDLE;
                rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b0, W_NONE, ST_SKIP, 2'b10};
                n = n + 2'd1;
              end
            end
            PH_BYPASS: begin
              if (g < 16'(swr_good_i)) begin
                phase_d = PH_IDLE;
                rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b0, W_NONE, ST_SKIP, 2'b10};
                n = n + 2'd1;
              end else begin
                rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b0, W_NONE, ST_BYPASS, 2'b00};
                n = n + 2'd1;
                rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b0, W_NONE, ST_COARSE, 2'b00};
                n = n + 2'd1;
                first_swr_d = g; second_d = 0;
                cts = 1;
              end
            end
            PH_CC_BASE: begin
              if (g == 0) ctm = 1;
              else begin
                inner_min_d = hyst({1'b0, g});
                inner_d = CW'(st);
                cc = 1;
              end
            end
            PH_CC_STEP: begin
              if (g == 0) ctm = 1;
              else if ({1'b0, g} < inner_min_q) begin
                inner_min_d = hyst({1'b0, g});
                cap_now_d = PW'(inner_q);
                cap_span_d = 6'(st);
                if (g < 16'(swr_ok_i)) begin
                  rel_cap_d = cap_now_d; ctm = 1;
                end else begin
                  inner_d = inner_q + CW'(st); cc = 1;
                end
              end else begin
                rel_cap_d = cap_now_q; ctm = 1;
              end
            end
            PH_CT_MEAS: begin
              if (g == 0) sub = 1;
              else if ({1'b0, g} < outer_min_q) begin
                outer_min_d = hyst({1'b0, g});
                best_d = PW'(outer_q);
                saved_cap_d = cap_now_q;
                ind_span_d = 6'(st);
                scs_d = cap_span_q;
                if (g < 16'(swr_ok_i)) ctf = 1;
                else begin
                  outer_d = outer_q + CW'(st); ct = 1;
                end
              end else begin
                rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b0, W_NONE, ST_COARSE_END,
                           2'b00};
                n = n + 2'd1;
                ctf = 1;
              end
            end
            PH_AFTER_COARSE: begin
              if (g == 0 || g < 16'(swr_ok_i)) sub = 1;
              else begin fsh = 1; fsh_cap = 0; fine_d = 0; end
            end
            PH_SH_BASE: begin
              if (g == 0) sha = 1;
              else begin
                inner_min_d = {1'b0, g};
                pos = axis_cap_q ? cap_now_q : ind_now_q;
                span = axis_cap_q ? cap_span_q : ind_span_q;
                inner_d = (CW'(pos) > CW'(span)) ? CW'(pos) - CW'(span) : '0;
                shl = 1;
              end
            end
            PH_SH_STEP: begin
              if ({1'b0, g} >= inner_min_q && rem_q < 2'd2) begin
                rem_d = rem_q + 2'd1;
                rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b1, W_10MS, ST_NONE, 2'b00};
                n = n + 2'd1;
              end else if (g == 0) begin
                if (axis_cap_q) begin cap_now_d = best_q; rel_cap_d = best_q; end
                else begin ind_now_d = best_q; rel_ind_d = best_q; end
                sha = 1;
              end else begin
                if ({1'b0, g} < inner_min_q) begin
                  inner_min_d = {1'b0, g};
                  best_d = PW'(inner_q);
                end
                if ({1'b0, g} < inner_min_q && g < 16'(swr_ok_i)) she = 1;
                else begin inner_d = inner_q + 1'b1; shl = 1; end
              end
            end
            PH_AFTER_SHARP: begin
              if (g == 0 || g < 16'(swr_ok_i)) sub = 1;
              else if (!axis_cap_q) begin fsh = 1; fsh_cap = 1; fine_d = 0; end
              else sas = 1;
            end
            PH_SW2_FIRST: begin
              if (g == 0 || g < 16'(swr_ok_i)) sub = 1; else cts = 1;
            end
            PH_RETRY: begin
              if (g == 0) begin
                ind_now_d = 0; cap_now_d = 0; sw_d = 0; rel_ind_d = 0; rel_cap_d = 0;
                phase_d = PH_IDLE;
                rb_d[n] = {14'd0, 1'b0, 1'b0, W_NONE, ST_ABORT, 2'b10};
                n = n + 2'd1;
              end else begin
                rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b0, W_NONE, ST_RETRY, 2'b00};
                n = n + 2'd1;
                post = 1;
              end
            end
            default: phase_d = PH_IDLE;
          endcase

          // Sequenced helpers, in dependency order.
          if (cts) begin
            saved_cap_d = 0; scs_d = 6'(st); ind_span_d = 6'(st);
            outer_min_d = hyst({1'b0, cur_d}); best_d = 0; outer_d = 0; ct = 1;
          end
          if (ct) begin
            if (outer_d > RMAX) ctf = 1;
            else begin
              ind_now_d = PW'(outer_d); rel_ind_d = PW'(outer_d);
              cap_now_d = 0; rel_cap_d = 0; cap_span_d = 6'(st); rem_d = 0;
              phase_d = PH_CC_BASE;
              rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b1, W_NONE, ST_NONE, 2'b00};
              n = n + 2'd1;
            end
          end
          if (cc) begin
            if (inner_d > RMAX) begin rel_cap_d = cap_now_d; ctm = 1; end
            else begin
              rel_cap_d = PW'(inner_d); rem_d = 0; phase_d = PH_CC_STEP;
              rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b1, W_NONE, ST_NONE, 2'b00};
              n = n + 2'd1;
            end
          end
          if (ctm) begin
            rem_d = 0; phase_d = PH_CT_MEAS;
            rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b1, W_NONE, ST_NONE, 2'b00};
            n = n + 2'd1;
          end
          if (ctf) begin
            ind_now_d = best_d; cap_now_d = saved_cap_d; cap_span_d = scs_d;
            rel_ind_d = best_d; rel_cap_d = saved_cap_d; phase_d = PH_AFTER_COARSE;
            rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b1, W_10MS, ST_NONE, 2'b00};
            n = n + 2'd1;
          end
          if (shl) begin
            pos = axis_cap_q ? cap_now_d : ind_now_d;
            span = axis_cap_q ? cap_span_d : ind_span_d;
            sum = CW'(pos) + CW'(span);
            hi = (sum > RMAX) ? RMAX : sum;
            if (inner_d <= hi && inner_d == CW'(best_d)) inner_d = inner_d + 1'b1;
            if (inner_d > hi) she = 1;
            else begin
              if (axis_cap_q) rel_cap_d = PW'(inner_d); else rel_ind_d = PW'(inner_d);
              rem_d = 0; phase_d = PH_SH_STEP;
              rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b1, W_NONE, ST_NONE, 2'b00};
              n = n + 2'd1;
            end
          end
          if (she) begin
            if (axis_cap_q) begin cap_now_d = best_d; rel_cap_d = best_d; end
            else begin ind_now_d = best_d; rel_ind_d = best_d; end
            rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b0, W_NONE,
                       axis_cap_q ? ST_CAP_DONE : ST_IND_DONE, 2'b00};
            n = n + 2'd1;
            sha = 1;
          end
          if (sha) begin
            if (fine_q) begin
              if (!axis_cap_q) begin fsh = 1; fsh_cap = 1; fine_d = 1; end
              else begin
                phase_d = PH_IDLE;
                rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b0, W_NONE, ST_DONE, 2'b10};
                n = n + 2'd1;
              end
            end else if (cur_d == 0) sub = 1;
            else begin
              phase_d = PH_AFTER_SHARP;
              rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b1, W_NONE, ST_NONE, 2'b00};
              n = n + 2'd1;
            end
          end
          if (sas) begin
            if (!second_q) begin
              if (g < 16'(Sw1KeepLimit) && g < first_swr_q &&
                  first_swr_q - g > 16'(Sw1KeepGain)) sub = 1;
              else begin
                first_swr_d = g; first_ind_d = ind_now_q; first_cap_d = cap_now_q;
                rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b0, W_NONE, ST_SW_TRY, 2'b00};
                n = n + 2'd1;
                sw_d = !sw_q;
                ind_now_d = 0; cap_now_d = 0; rel_ind_d = 0; rel_cap_d = 0;
                second_d = 1; phase_d = PH_SW2_FIRST;
                rb_d[n] = {14'd0, sw_d, 1'b1, W_50MS, ST_NONE, 2'b00};
                n = n + 2'd1;
              end
            end else begin
              sas_kind = (g > first_swr_q);
              rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b0, W_NONE,
                         sas_kind ? ST_SW_BACK : ST_SW_KEEP, 2'b00};
              n = n + 2'd1;
              if (sas_kind) begin
                sw_d = !sw_q;
                ind_now_d = first_ind_q; cap_now_d = first_cap_q;
                rel_ind_d = first_ind_q; rel_cap_d = first_cap_q; cur_d = first_swr_q;
              end
              sub = 1;
            end
          end
          if (sub) begin
            if (cur_d == 0) begin
              phase_d = PH_RETRY;
              rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b1, W_RETRY, ST_NONE, 2'b00};
              n = n + 2'd1;
            end else post = 1;
          end
          if (post) begin
            if (cur_d < 16'(swr_ok_i)) begin
              phase_d = PH_IDLE;
              rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b0, W_NONE, ST_OK, 2'b10};
              n = n + 2'd1;
            end else begin
              rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b0, W_NONE, ST_FINE, 2'b00};
              n = n + 2'd1;
              ind_span_d = 6'(st); cap_span_d = 6'(st);
              fsh = 1; fsh_cap = 0; fine_d = 1;
            end
          end
          if (fsh) begin
            axis_cap_d = fsh_cap;
            best_d = fsh_cap ? cap_now_d : ind_now_d;
            phase_d = PH_SH_BASE;
            rb_d[n] = {7'(rel_ind_d), 7'(rel_cap_d), sw_d, 1'b1, W_NONE, ST_NONE, 2'b00};
            n = n + 2'd1;
          end
        end
      end
      if (n != 2'd0) rb_d[n - 2'd1].last = 1'b1;
      rn_d = n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      ind_now_q <= '0; cap_now_q <= '0; rel_ind_q <= '0; rel_cap_q <= '0;
      saved_cap_q <= '0; best_q <= '0; first_ind_q <= '0; first_cap_q <= '0;
      sw_q <= 1'b0; axis_cap_q <= 1'b0; fine_q <= 1'b0; second_q <= 1'b0;
      ind_span_q <= '0; cap_span_q <= '0; scs_q <= '0;
      outer_q <= '0; inner_q <= '0; outer_min_q <= '0; inner_min_q <= '0;
      first_swr_q <= '0; cur_q <= '0; rem_q <= '0; pw_q <= '0;
      rn_q <= '0; rp_q <= '0;
    end else begin
      phase_q <= phase_d;
      ind_now_q <= ind_now_d; cap_now_q <= cap_now_d; rel_ind_q <= rel_ind_d;
      rel_cap_q <= rel_cap_d; saved_cap_q <= saved_cap_d; best_q <= best_d;
      first_ind_q <= first_ind_d; first_cap_q <= first_cap_d;
      sw_q <= sw_d; axis_cap_q <= axis_cap_d; fine_q <= fine_d; second_q <= second_d;
      ind_span_q <= ind_span_d; cap_span_q <= cap_span_d; scs_q <= scs_d;
      outer_q <= outer_d; inner_q <= inner_d; outer_min_q <= outer_min_d;
      inner_min_q <= inner_min_d; first_swr_q <= first_swr_d; cur_q <= cur_d;
      rem_q <= rem_d; pw_q <= pw_d;
      rn_q <= rn_d; rp_q <= rp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) rb_q[i] <= rb_d[i];
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) rn_q <= 2'd3)
    else $error("result count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (rp_q < rn_q)) else $error("read pointer past results");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_res_o.finished) |-> out_res_o.last)
    else $error("closing status not last");
endmodule

@@ sv/atsc_cfg.sv @@
// Configuration register file for the tuner controller.
// Depends on atsc_pkg.
module atsc_cfg import atsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  logic [CfgIdxW-1:0]  index_i,
  input  logic [CfgDataW-1:0] data_i,
  output logic [15:0]         min_power_o,
  output logic [9:0]          swr_ok_o,
  output logic [9:0]          swr_good_o,
  output logic [4:0]          coarse_step_o
);
  logic [15:0] mp_q;
  logic [9:0]  ok_q, gd_q;
  logic [4:0]  cs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mp_q <= 16'd10; ok_q <= 10'd110; gd_q <= 10'd120; cs_q <= 5'd3;
    end else if (wr_i) begin
      unique case (index_i)
        CFG_MIN_POWER:   mp_q <= data_i;
        CFG_SWR_OK:      ok_q <= data_i[9:0];
        CFG_SWR_GOOD:    gd_q <= data_i[9:0];
        CFG_COARSE_STEP: cs_q <= data_i[4:0];
        default: ;
      endcase
    end
  end

  assign min_power_o = mp_q;
  assign swr_ok_o = ok_q;
  assign swr_good_o = gd_q;
  assign coarse_step_o = cs_q;
endmodule

@@ sv/antenna_tuner_search_controller.sv @@
// Top level of the antenna tuner search controller.
// Uses channel interfaces from atsc_if and modules atsc_cfg, atsc_front, atsc_back.
//
// Channels: in (kind, swr, power), out (one result per transfer), cfg (index, data).
// A start item (kind 0) begins a tune; each later measurement while a tune runs moves
// the search by one step and yields one to three results, the final one marked by last.
// Measurements with power below min_power count as lost signal.
// The first result passes through the queue, then the output buffer, both
// registered, before it is valid. Throughput: one input per cycle when each
// input gives one result and the receiver keeps ready high; an input with
// more than one result holds the output buffer until all have transferred
// through the single output port.
// A two-entry queue sits between front and back, so input transfers continue
// for two items while the receiver stalls; then ready drops.
// Reset clears the phase to idle, relays to zero and registers to defaults.
// The retry wait that wait class 5 refers to is kept by the host; a write to its
// index is accepted and changes nothing here.
// Configuration writes are always ready and should be made while idle.
module antenna_tuner_search_controller import atsc_pkg::*; #(
  parameter int unsigned RelayMax = RelayMaxDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  atsc_in_if.sink    in_if,
  atsc_out_if.source out_if,
  atsc_cfg_if.sink   cfg_if
);
  logic [15:0] min_power;
  logic [9:0]  swr_ok, swr_good;
  logic [4:0]  coarse_step;
  logic        q_valid, q_ready;
  item_t       q_item;
  res_t        res;

  assign cfg_if.ready = 1'b1;

  atsc_cfg u_cfg (
    .clk_i, .rst_ni,
    .wr_i(cfg_if.valid), .index_i(cfg_if.index), .data_i(cfg_if.data),
    .min_power_o(min_power), .swr_ok_o(swr_ok), .swr_good_o(swr_good),
    .coarse_step_o(coarse_step)
  );

  atsc_front u_front (
    .clk_i, .rst_ni, .min_power_i(min_power),
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .kind_i(in_if.kind), .swr_i(in_if.swr), .power_i(in_if.power),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  atsc_back #(.RelayMax(RelayMax)) u_back (
    .clk_i, .rst_ni, .swr_ok_i(swr_ok), .swr_good_i(swr_good),
    .coarse_step_i(coarse_step),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_res_o(res)
  );

  assign out_if.ind_bits = res.ind_bits;
  assign out_if.cap_bits = res.cap_bits;
  assign out_if.sw_pos = res.sw_pos;
  assign out_if.measure = res.measure;
  assign out_if.wait_class = res.wait_class;
  assign out_if.status = res.status;
  assign out_if.finished = res.finished;
  assign out_if.last = res.last;
endmodule
